>>> rtl/core/lsa_pkg.sv
package lsa_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int SIZE_W      = OFFSET_BITS + 1;
    localparam int ALIGN_BYTES = 8;

    localparam logic [SIZE_W-1:0] POOL_LIMIT = SIZE_W'(1) << OFFSET_BITS;
    localparam logic [SIZE_W-1:0] POOL_RESET = POOL_LIMIT;
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXHAUSTED  = 3'd1,
        ST_STACK_FULL = 3'd2,
        ST_NOT_TOP    = 3'd3,
        ST_NULL_FREE  = 3'd4
    } lsa_status_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic cfg_write;
    } lsa_cmd_t;

endpackage

>>> rtl/core/lifo_stack_allocator_core.sv
// Channel   Handshake                Word
// in        in_valid / in_stall      op, request_bytes, block_offset, is_null
// out       out_valid / out_stall    result_offset, status, used_bytes, peak_bytes, free_bytes
// cfg       cfg_valid / cfg_ready    cfg_data (pool size in bytes)
//
// A request is handled in order: the accept cycle reads the top stack entry from the
// block memory into a register, and the S_EXEC state then commits the allocate or free.
// A finished word waits in the output register while the next request is accepted.
// Commit is held back only while the output register is full and stalled.
// Reset is asynchronous and active low; the pool then holds 65536 free bytes.
module lifo_stack_allocator_core #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [lsa_pkg::OFFSET_BITS-1:0] request_bytes,
    input  logic [lsa_pkg::OFFSET_BITS-1:0] block_offset,
    input  logic                            is_null,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lsa_pkg::OFFSET_BITS-1:0] result_offset,
    output logic [2:0]                      status,
    output logic [lsa_pkg::SIZE_W-1:0]      used_bytes,
    output logic [lsa_pkg::SIZE_W-1:0]      peak_bytes,
    output logic [lsa_pkg::SIZE_W-1:0]      free_bytes,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsa_pkg::SIZE_W-1:0]      cfg_data
);
    import lsa_pkg::*;

    lsa_cmd_t cmd;

    lsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    lsa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .request_bytes (request_bytes),
        .block_offset  (block_offset),
        .is_null       (is_null),
        .cfg_data      (cfg_data),
        .result_offset (result_offset),
        .status        (status),
        .used_bytes    (used_bytes),
        .peak_bytes    (peak_bytes),
        .free_bytes    (free_bytes)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous request still executing");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(ST_NULL_FREE))
        else $error("status code out of range");

    a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_bytes >= used_bytes)
        else $error("peak usage below current usage");

    a_offset_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'(ST_OK) |-> result_offset == '0)
        else $error("nonzero offset on a failed or free request");
`endif

endmodule

>>> rtl/core/lsa_ctrl.sv
module lsa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    output lsa_pkg::lsa_cmd_t cmd
);
    import lsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } lsa_state_t;

    lsa_state_t state_reg;
    lsa_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd.capture     = 1'b0;
        cmd.commit      = 1'b0;
        cmd.cfg_write   = cfg_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/lsa_datapath.sv
module lsa_datapath #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsa_pkg::lsa_cmd_t               cmd,
    input  logic                            op,
    input  logic [lsa_pkg::OFFSET_BITS-1:0] request_bytes,
    input  logic [lsa_pkg::OFFSET_BITS-1:0] block_offset,
    input  logic                            is_null,
    input  logic [lsa_pkg::SIZE_W-1:0]      cfg_data,
    output logic [lsa_pkg::OFFSET_BITS-1:0] result_offset,
    output logic [2:0]                      status,
    output logic [lsa_pkg::SIZE_W-1:0]      used_bytes,
    output logic [lsa_pkg::SIZE_W-1:0]      peak_bytes,
    output logic [lsa_pkg::SIZE_W-1:0]      free_bytes
);
    import lsa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [OFFSET_BITS-1:0] off_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0]      size_mem [MAX_BLOCKS];

    logic [SIZE_W-1:0]      next_free_reg, next_free_next;
    logic [SIZE_W-1:0]      left_reg, left_next;
    logic [SIZE_W-1:0]      in_use_reg, in_use_next;
    logic [SIZE_W-1:0]      peak_reg, peak_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   op_reg;
    logic [OFFSET_BITS-1:0] req_reg;
    logic [OFFSET_BITS-1:0] offs_reg;
    logic                   null_reg;

    logic [OFFSET_BITS-1:0] top_off_reg;
    logic [SIZE_W-1:0]      top_size_reg;

    logic [OFFSET_BITS-1:0] res_off_reg, res_off_next;
    lsa_status_t            status_reg, status_next;
    logic [SIZE_W-1:0]      out_used_reg, out_peak_reg, out_free_reg;

    logic [CNT_W-1:0]       top_pos;
    logic [SIZE_W-1:0]      aligned;
    logic [SIZE_W-1:0]      used_sum;
    logic                   push;
    logic [SIZE_W-1:0]      cfg_pool;

    assign top_pos  = count_reg - CNT_W'(1);
    assign aligned  = (SIZE_W'(req_reg) + ALIGN_MASK) & ~ALIGN_MASK;
    assign used_sum = in_use_reg + aligned;
    assign cfg_pool = (cfg_data > POOL_LIMIT) ? POOL_LIMIT : cfg_data;

    always_comb
    begin
        next_free_next = next_free_reg;
        left_next      = left_reg;
        in_use_next    = in_use_reg;
        peak_next      = peak_reg;
        count_next     = count_reg;
        res_off_next   = '0;
        status_next    = ST_OK;
        push           = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            if (aligned > left_reg)
            begin
                status_next = ST_EXHAUSTED;
            end
            else if (count_reg == CNT_W'(MAX_BLOCKS))
            begin
                status_next = ST_STACK_FULL;
            end
            else
            begin
                push           = 1'b1;
                res_off_next   = next_free_reg[OFFSET_BITS-1:0];
                count_next     = count_reg + CNT_W'(1);
                next_free_next = next_free_reg + aligned;
                left_next      = left_reg - aligned;
                in_use_next    = used_sum;
                if (used_sum > peak_reg)
                begin
                    peak_next = used_sum;
                end
            end
        end
        else
        begin
            if (null_reg)
            begin
                status_next = ST_NULL_FREE;
            end
            else if (count_reg == '0 || top_off_reg != offs_reg)
            begin
                status_next = ST_NOT_TOP;
            end
            else
            begin
                count_next     = top_pos;
                next_free_next = (next_free_reg >= top_size_reg) ?
                                 next_free_reg - top_size_reg : '0;
                in_use_next    = (in_use_reg >= top_size_reg) ?
                                 in_use_reg - top_size_reg : '0;
                left_next      = left_reg + top_size_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
        begin
            off_mem[count_reg[IDX_W-1:0]]  <= next_free_reg[OFFSET_BITS-1:0];
            size_mem[count_reg[IDX_W-1:0]] <= aligned;
        end
        top_off_reg  <= off_mem[top_pos[IDX_W-1:0]];
        top_size_reg <= size_mem[top_pos[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            req_reg  <= request_bytes;
            offs_reg <= block_offset;
            null_reg <= is_null;
        end
        if (cmd.commit)
        begin
            res_off_reg  <= res_off_next;
            status_reg   <= status_next;
            out_used_reg <= in_use_next;
            out_peak_reg <= peak_next;
            out_free_reg <= left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            left_reg      <= POOL_RESET;
            in_use_reg    <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            next_free_reg <= next_free_next;
            left_reg      <= left_next;
            in_use_reg    <= in_use_next;
            peak_reg      <= peak_next;
            count_reg     <= count_next;
        end
        else if (cmd.cfg_write && count_reg == '0)
        begin
            next_free_reg <= '0;
            in_use_reg    <= '0;
            left_reg      <= cfg_pool;
        end
    end

    assign result_offset = res_off_reg;
    assign status        = status_reg;
    assign used_bytes    = out_used_reg;
    assign peak_bytes    = out_peak_reg;
    assign free_bytes    = out_free_reg;

endmodule
